// File: rtl/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// shared types and constants for the nec infrared edge decoder
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

    // decoder phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_LEAD_LOW  = 3'd1;
    localparam logic [2:0] PH_LEAD_HIGH = 3'd2;
    localparam logic [2:0] PH_DATA      = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;

    // item kinds carried in tuser
    localparam logic ACT_EDGE  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // window register indexes
    localparam int NUM_WIN = 6;
    localparam logic [2:0] WIN_LEADER_LOW  = 3'd0;
    localparam logic [2:0] WIN_LEADER_HIGH = 3'd1;
    localparam logic [2:0] WIN_REPEAT_HIGH = 3'd2;
    localparam logic [2:0] WIN_BIT_LOW     = 3'd3;
    localparam logic [2:0] WIN_ZERO_HIGH   = 3'd4;
    localparam logic [2:0] WIN_ONE_HIGH    = 3'd5;

    // window reset values, maximum in the upper half, minimum in the lower
    localparam logic [31:0] WIN_LEADER_LOW_RST  = 32'h251C_2134; // 8500..9500
    localparam logic [31:0] WIN_LEADER_HIGH_RST = 32'h1388_0FA0; // 4000..5000
    localparam logic [31:0] WIN_REPEAT_HIGH_RST = 32'h09C4_07D0; // 2000..2500
    localparam logic [31:0] WIN_BIT_LOW_RST     = 32'h02BC_0190; // 400..700
    localparam logic [31:0] WIN_ZERO_HIGH_RST   = 32'h02BC_0190; // 400..700
    localparam logic [31:0] WIN_ONE_HIGH_RST    = 32'h076C_05DC; // 1500..1900

    localparam int FRAME_W = 32;
    localparam int OUT_W   = 64;

    typedef logic [NUM_WIN-1:0][31:0] win_array_t;

    // decoder state shared between the top level and the step logic
    typedef struct packed {
        logic [2:0]         phase;
        logic [FRAME_W-1:0] frame;
        logic [5:0]         bits;
        logic               ready;
        logic               rep;
        logic [7:0]         last_cmd;
    } dec_state_t;

    // inclusive window check, an inverted window never matches
    function automatic logic in_window(input logic [31:0] val, input logic [31:0] win);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = {16'd0, win[15:0]};
        hi = {16'd0, win[31:16]};
        return (val >= lo) && (val <= hi);
    endfunction

endpackage

`default_nettype wire

// File: rtl/nec_ir_edge_decoder_unit.sv
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder_unit
// nec infrared remote decoder driven by timestamped pin edges
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item per edge or clear command: tuser is the kind
//   (edge or clear), tdata holds the microsecond timestamp and the pin level.
//   every accepted item yields exactly one result item on m_axis reporting
//   the decoder state after that item: ready, repeat flag, frame, address
//   and command bytes with their inverse checks, held command and phase.
//   cfg writes the six timing windows (index 0..5), each a 16-bit minimum
//   in the low half and a 16-bit maximum in the high half; other indexes
//   are ignored. cfg_ready is always high; write only while no item is
//   in flight.
// timing
//   an accepted item's result is registered and shows on m_axis in the next
//   cycle. one item per cycle is sustained while m_axis takes results, set by
//   the single output register after the subtract-and-compare step.
// reset and stall
//   rst_n clears the decoder to idle and loads the default windows; no
//   clearing pass. when m_axis stalls, the result holds in the output
//   register and s_axis_tready drops until it is taken; a result taken in
//   the same cycle frees the register for the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_edge_decoder_unit
    import necir_pkg::*;
#(
    parameter int TIMER_WIDTH  = 16,
    parameter int FRAME_LENGTH = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input items
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata: edge_time [TIMER_WIDTH-1:0], level_high, zero fill
    input  wire logic [((TIMER_WIDTH+8)/8)*8-1:0] s_axis_tdata,
    // tuser: action (0 edge, 1 clear)
    input  wire logic                s_axis_tuser,
    // result items
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // tdata: ready_res, repeat_flag, raw_frame[31:0], address_byte[7:0],
    // command_byte[7:0], address_check_ok, command_check_ok,
    // held_command[7:0], decoder_phase[2:0], one zero fill bit
    output logic [OUT_W-1:0]         m_axis_tdata,
    // configuration writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    // decoder state
    dec_state_t             state_reg;
    dec_state_t             state_next;
    logic [TIMER_WIDTH-1:0] prev_time_reg;
    logic [TIMER_WIDTH-1:0] prev_time_next;

    // timing windows
    win_array_t             win_reg;

    // output register
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg;
    logic [OUT_W-1:0]       m_data_next;

    logic                   s_fire;
    logic                   addr_ok;
    logic                   cmd_ok;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    necir_step #(
        .TIMER_WIDTH  (TIMER_WIDTH),
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_step (
        .cur        (state_reg),
        .prev_time  (prev_time_reg),
        .win        (win_reg),
        .action     (s_axis_tuser),
        .edge_time  (s_axis_tdata[TIMER_WIDTH-1:0]),
        .level_high (s_axis_tdata[TIMER_WIDTH]),
        .nxt        (state_next),
        .nxt_time   (prev_time_next)
    );

    // byte checks on the updated frame
    assign addr_ok = (state_next.frame[7:0]   == ~state_next.frame[15:8]);
    assign cmd_ok  = (state_next.frame[23:16] == ~state_next.frame[31:24]);

    assign m_data_next = {1'b0,
                          state_next.phase,
                          state_next.last_cmd,
                          cmd_ok,
                          addr_ok,
                          state_next.frame[23:16],
                          state_next.frame[7:0],
                          state_next.frame,
                          state_next.rep,
                          state_next.ready};

    // decoder state, updated once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            prev_time_reg <= '0;
        end
        else if (s_fire)
        begin
            state_reg     <= state_next;
            prev_time_reg <= prev_time_next;
        end
    end

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[WIN_LEADER_LOW]  <= WIN_LEADER_LOW_RST;
            win_reg[WIN_LEADER_HIGH] <= WIN_LEADER_HIGH_RST;
            win_reg[WIN_REPEAT_HIGH] <= WIN_REPEAT_HIGH_RST;
            win_reg[WIN_BIT_LOW]     <= WIN_BIT_LOW_RST;
            win_reg[WIN_ZERO_HIGH]   <= WIN_ZERO_HIGH_RST;
            win_reg[WIN_ONE_HIGH]    <= WIN_ONE_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                WIN_LEADER_LOW:  win_reg[WIN_LEADER_LOW]  <= cfg_data;
                WIN_LEADER_HIGH: win_reg[WIN_LEADER_HIGH] <= cfg_data;
                WIN_REPEAT_HIGH: win_reg[WIN_REPEAT_HIGH] <= cfg_data;
                WIN_BIT_LOW:     win_reg[WIN_BIT_LOW]     <= cfg_data;
                WIN_ZERO_HIGH:   win_reg[WIN_ZERO_HIGH]   <= cfg_data;
                WIN_ONE_HIGH:    win_reg[WIN_ONE_HIGH]    <= cfg_data;
                default:         ; // indexes past the list are dropped
            endcase
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_fire)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_fire)
            m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    // a done frame always carries the ready flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DONE) |-> state_reg.ready)
        else $error("done phase without ready flag");

    // a repeat code is only flagged together with ready
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rep |-> state_reg.ready)
        else $error("repeat flag without ready flag");

    // the bit count never runs past the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bits <= 6'(FRAME_LENGTH))
        else $error("bit count beyond frame length");

    // a clear leaves the decoder idle and not ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_axis_tuser == ACT_CLEAR)) |=>
            (!state_reg.ready && (state_reg.phase == PH_IDLE) && (prev_time_reg == '0)))
        else $error("clear did not restart the decoder");

    // a held result stays stable while it is stalled and no item is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready && !s_fire) |=> $stable(m_data_reg))
        else $error("held result changed");
`endif

endmodule

`default_nettype wire

// File: rtl/necir_step.sv
// ----------------------------------------------------------------------------
// necir_step
// next-state logic of the decoder for one accepted item
// ----------------------------------------------------------------------------
`default_nettype none

module necir_step
    import necir_pkg::*;
#(
    parameter int TIMER_WIDTH  = 16,
    parameter int FRAME_LENGTH = 32
)
(
    input  wire dec_state_t             cur,
    input  wire logic [TIMER_WIDTH-1:0] prev_time,
    input  wire win_array_t             win,
    input  wire logic                   action,
    input  wire logic [TIMER_WIDTH-1:0] edge_time,
    input  wire logic                   level_high,
    output dec_state_t                  nxt,
    output logic [TIMER_WIDTH-1:0]      nxt_time
);

    localparam logic [5:0] FRAME_BITS = 6'(FRAME_LENGTH);

    logic [TIMER_WIDTH-1:0] dur;
    logic [31:0]            dur_ext;
    logic                   abort;
    logic [FRAME_W-1:0]     bit_mask;

    assign dur      = edge_time - prev_time;
    assign dur_ext  = 32'(dur);
    assign bit_mask = FRAME_W'(1) << cur.bits[4:0];

    always_comb
    begin
        nxt      = cur;
        nxt_time = edge_time;
        abort    = 1'b0;
        if (action == ACT_CLEAR)
        begin
            nxt.ready = 1'b0;
            abort     = 1'b1;
        end
        else
        begin
            unique case (cur.phase)
                PH_IDLE:
                begin
                    if (!level_high)
                        nxt.phase = PH_LEAD_LOW;
                end
                PH_LEAD_LOW:
                begin
                    if (level_high && in_window(dur_ext, win[WIN_LEADER_LOW]))
                        nxt.phase = PH_LEAD_HIGH;
                    else
                        abort = 1'b1;
                end
                PH_LEAD_HIGH:
                begin
                    if (level_high)
                        abort = 1'b1;
                    else if (in_window(dur_ext, win[WIN_LEADER_HIGH]))
                    begin
                        nxt.phase = PH_DATA;
                        nxt.frame = '0;
                        nxt.bits  = '0;
                        nxt.rep   = 1'b0;
                    end
                    else if (in_window(dur_ext, win[WIN_REPEAT_HIGH]))
                    begin
                        nxt.phase = PH_IDLE;
                        nxt.frame = '0;
                        nxt.bits  = '0;
                        nxt.rep   = 1'b1;
                        nxt.ready = 1'b1;
                    end
                    else
                        abort = 1'b1;
                end
                PH_DATA:
                begin
                    if (level_high)
                    begin
                        if (!in_window(dur_ext, win[WIN_BIT_LOW]))
                            abort = 1'b1;
                    end
                    else
                    begin
                        if (cur.bits < FRAME_BITS)
                        begin
                            if (in_window(dur_ext, win[WIN_ZERO_HIGH]))
                            begin
                                nxt.frame = cur.frame & ~bit_mask;
                                nxt.bits  = cur.bits + 6'd1;
                            end
                            else if (in_window(dur_ext, win[WIN_ONE_HIGH]))
                            begin
                                nxt.frame = cur.frame | bit_mask;
                                nxt.bits  = cur.bits + 6'd1;
                            end
                            else
                                abort = 1'b1;
                        end
                        // frame complete once the last gap is counted
                        if (!abort && (nxt.bits == FRAME_BITS))
                        begin
                            nxt.last_cmd = nxt.frame[23:16];
                            nxt.ready    = 1'b1;
                            nxt.phase    = PH_DONE;
                        end
                    end
                end
                PH_DONE:
                begin
                    nxt = cur;
                end
                default:
                begin
                    abort = 1'b1;
                end
            endcase
        end

        if (abort)
        begin
            nxt.phase = PH_IDLE;
            nxt.frame = '0;
            nxt.bits  = '0;
            nxt.rep   = 1'b0;
            nxt_time  = '0;
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_nec_ir_edge_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_nec_ir_edge_decoder_unit
// self-checking bench for the nec infrared edge decoder
// ----------------------------------------------------------------------------
// drives timestamped pin edges and clear commands into the decoder and keeps
// a cycle-free model of the nec frame decoder alongside it. every item on the
// input stream predicts one report item, which is compared field by field
// with what comes out. a short directed table walks the leader, repeat and
// bit window edges, wraparound and aborts; random traffic then sends whole
// frames, repeat codes, damaged frames and noise under several window
// settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------

module tb_nec_ir_edge_decoder_unit;
    import necir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits and the stretch with no idling on either side
    localparam int CYCLE_LIMIT = 200000;
    localparam int CALM_LO     = 700;
    localparam int CALM_HI     = 1000;

    // report item, laid out as m_axis_tdata from the top bit down
    typedef struct packed {
        logic       pad;
        logic [2:0] phase;
        logic [7:0] held;
        logic       cmd_ok;
        logic       addr_ok;
        logic [7:0] cmd;
        logic [7:0] addr;
        logic [31:0] frame;
        logic       rep;
        logic       ready;
    } ir_report_t;

    // one row of the directed table
    typedef struct packed {
        logic       kind;
        logic [15:0] ts;
        logic       lvl;
        logic       typed;
        logic       ready;
        logic       rep;
        logic [2:0] ph;
    } probe_row_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // dut ports, all driven from time zero
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // edge_time[15:0], level_high, zero fill
    logic        s_axis_tuser  = ACT_EDGE; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;  // ready_res, repeat_flag, raw_frame[31:0],
                                // address_byte[7:0], command_byte[7:0],
                                // address_check_ok, command_check_ok,
                                // held_command[7:0], decoder_phase[2:0], fill
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    nec_ir_edge_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // decoder model state
    win_array_t   win_model;
    logic [2:0]   dec_phase = PH_IDLE;
    logic [31:0]  dec_frame = '0;
    int           dec_bits  = 0;
    logic         dec_ready = 1'b0;
    logic         dec_rep   = 1'b0;
    logic [7:0]   dec_last  = '0;
    logic [15:0]  dec_prev  = '0;

    // pending reports, oldest first
    ir_report_t   report_q[$];
    probe_row_t   probes[$];

    // bookkeeping
    int          sent         = 0;
    int          checked      = 0;
    int          errors       = 0;
    int          cycles       = 0;
    int          frames_done  = 0;
    int          repeats_done = 0;
    int          clears       = 0;
    logic [15:0] now_us       = '0;
    logic [15:0] probe_t      = '0;

    function automatic win_array_t default_windows();
        win_array_t wins;
        wins[WIN_LEADER_LOW]  = WIN_LEADER_LOW_RST;
        wins[WIN_LEADER_HIGH] = WIN_LEADER_HIGH_RST;
        wins[WIN_REPEAT_HIGH] = WIN_REPEAT_HIGH_RST;
        wins[WIN_BIT_LOW]     = WIN_BIT_LOW_RST;
        wins[WIN_ZERO_HIGH]   = WIN_ZERO_HIGH_RST;
        wins[WIN_ONE_HIGH]    = WIN_ONE_HIGH_RST;
        return wins;
    endfunction

    // inclusive; an inverted window never matches
    function automatic bit fits(input logic [15:0] val, input logic [31:0] win);
        return val >= win[15:0] && val <= win[31:16];
    endfunction

    function automatic void drop_frame();
        dec_phase = PH_IDLE;
        dec_frame = '0;
        dec_bits  = 0;
        dec_rep   = 1'b0;
        dec_prev  = '0;
    endfunction

    // advance the decoder model by one item and return the report it gives
    function automatic ir_report_t decode_step(input logic kind, input logic [15:0] ts,
                                               input logic lvl);
        ir_report_t r;
        logic [15:0] gap;
        if (kind == ACT_CLEAR)
        begin
            dec_ready = 1'b0;
            dec_rep   = 1'b0;
            drop_frame();
            clears++;
        end
        else
        begin
            gap      = ts - dec_prev;
            dec_prev = ts;
            case (dec_phase)
                PH_IDLE:
                    if (!lvl)
                        dec_phase = PH_LEAD_LOW;
                PH_LEAD_LOW:
                    if (lvl && fits(gap, win_model[WIN_LEADER_LOW]))
                        dec_phase = PH_LEAD_HIGH;
                    else
                        drop_frame();
                PH_LEAD_HIGH:
                    if (lvl)
                        drop_frame();
                    else if (fits(gap, win_model[WIN_LEADER_HIGH]))
                    begin
                        dec_phase = PH_DATA;
                        dec_frame = '0;
                        dec_bits  = 0;
                        dec_rep   = 1'b0;
                    end
                    else if (fits(gap, win_model[WIN_REPEAT_HIGH]))
                    begin
                        dec_rep   = 1'b1;
                        dec_ready = 1'b1;
                        dec_phase = PH_IDLE;
                        dec_frame = '0;
                        dec_bits  = 0;
                        repeats_done++;
                    end
                    else
                        drop_frame();
                PH_DATA:
                    if (lvl)
                    begin
                        if (!fits(gap, win_model[WIN_BIT_LOW]))
                            drop_frame();
                    end
                    else
                    begin
                        if (dec_bits < FRAME_W)
                        begin
                            // zero window wins where the two overlap
                            if (fits(gap, win_model[WIN_ZERO_HIGH]))
                            begin
                                dec_frame[dec_bits] = 1'b0;
                                dec_bits++;
                            end
                            else if (fits(gap, win_model[WIN_ONE_HIGH]))
                            begin
                                dec_frame[dec_bits] = 1'b1;
                                dec_bits++;
                            end
                            else
                                drop_frame();
                        end
                        if (dec_bits == FRAME_W)
                        begin
                            dec_last  = dec_frame[23:16];
                            dec_ready = 1'b1;
                            dec_phase = PH_DONE;
                            frames_done++;
                        end
                    end
                PH_DONE:
                    ;
                default:
                    drop_frame();
            endcase
        end
        r         = '0;
        r.ready   = dec_ready;
        r.rep     = dec_rep;
        r.frame   = dec_frame;
        r.addr    = dec_frame[7:0];
        r.cmd     = dec_frame[23:16];
        r.addr_ok = dec_frame[7:0] == ~dec_frame[15:8];
        r.cmd_ok  = dec_frame[23:16] == ~dec_frame[31:24];
        r.held    = dec_last;
        r.phase   = dec_phase;
        return r;
    endfunction

    // report with an empty frame, as seen before any frame completes
    function automatic ir_report_t idle_report(input logic rdy, input logic rep,
                                               input logic [2:0] ph);
        ir_report_t r;
        r       = '0;
        r.ready = rdy;
        r.rep   = rep;
        r.phase = ph;
        return r;
    endfunction

    task automatic add_probe(input logic kind, input logic [15:0] delta, input logic lvl,
                             input logic typed, input logic rdy, input logic rep,
                             input logic [2:0] ph);
        probe_t += delta;
        probes.push_back({kind, probe_t, lvl, typed, rdy, rep, ph});
    endtask

    // present one item, wait for the handshake, then log what it should give
    task automatic send_item(input logic kind, input logic [15:0] ts, input logic lvl,
                             input logic typed, input ir_report_t typed_val);
        ir_report_t guess;
        while (!(sent >= CALM_LO && sent < CALM_HI) && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, lvl, ts};
        do
            @(posedge clk);
        while (!s_axis_tready);
        guess = decode_step(kind, ts, lvl);
        report_q.push_back(typed ? typed_val : guess);
        sent++;
    endtask

    // hold the sender back until every outstanding report is in
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
    endtask

    // pulse width inside the window, or for a damaged edge one past either limit or random
    function automatic logic [15:0] span_for(input logic [31:0] win, input bit hit);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = win[15:0];
        hi = win[31:16];
        if (hit && lo <= hi)
            return 16'($urandom_range(hi, lo));
        case ($urandom_range(2))
            0:       return lo - 16'd1;
            1:       return hi + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // one timed edge; a flawed one is either mistimed or of the wrong direction
    task automatic pulse(input logic [31:0] win, input logic lvl, input bit flaw);
        bit swap;
        swap = flaw && $urandom_range(1);
        now_us += span_for(win, !flaw || swap);
        send_item(ACT_EDGE, now_us, swap ? !lvl : lvl, 1'b0, '0);
    endtask

    task automatic leader_start();
        now_us += 16'($urandom);
        send_item(ACT_EDGE, now_us, 1'b0, 1'b0, '0);
    endtask

    task automatic send_frame(input logic [31:0] code, input int flaw);
        int i;
        leader_start();
        pulse(win_model[WIN_LEADER_LOW], 1'b1, flaw == 0);
        pulse(win_model[WIN_LEADER_HIGH], 1'b0, flaw == 1);
        for (i = 0; i < FRAME_W; i++)
        begin
            pulse(win_model[WIN_BIT_LOW], 1'b1, flaw == 2 + 2 * i);
            pulse(code[i] ? win_model[WIN_ONE_HIGH] : win_model[WIN_ZERO_HIGH], 1'b0,
                  flaw == 3 + 2 * i);
        end
    endtask

    task automatic send_repeat(input int flaw);
        leader_start();
        pulse(win_model[WIN_LEADER_LOW], 1'b1, flaw == 0);
        pulse(win_model[WIN_REPEAT_HIGH], 1'b0, flaw == 1);
    endtask

    task automatic send_clear();
        send_item(ACT_CLEAR, 16'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // random traffic, frames for the most part, until the item count is met
    task automatic run_traffic(input int target);
        int          pick;
        int          n;
        logic [7:0]  a;
        logic [7:0]  c;
        logic [31:0] code;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            a    = 8'($urandom);
            c    = 8'($urandom);
            code = ($urandom_range(99) < 60) ? {~c, c, ~a, a} : $urandom;
            if (pick < 45)
                send_frame(code, -1);
            else if (pick < 60)
                send_frame(code, $urandom_range(2 + 2 * FRAME_W - 1));
            else if (pick < 75)
                send_repeat(($urandom_range(3) == 0) ? $urandom_range(1) : -1);
            else if (pick < 88)
            begin
                // line noise: a burst of edges at random times and levels
                for (n = $urandom_range(6, 1); n > 0; n--)
                begin
                    now_us += 16'($urandom);
                    send_item(ACT_EDGE, now_us, 1'($urandom), 1'b0, '0);
                end
            end
            else
                send_clear();
            // release a held frame most of the time so the next one can land
            if ($urandom_range(99) < 70)
                send_clear();
        end
    endtask

    // write the timing windows, and the unused indexes when asked
    task automatic apply_windows(input win_array_t wins, input bit spare);
        int k;
        drain();
        for (k = 0; k < (spare ? 8 : NUM_WIN); k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(k);
            cfg_data  <= (k < NUM_WIN) ? wins[k] : $urandom;
            do
                @(posedge clk);
            while (!cfg_ready);
            if (k < NUM_WIN)
                win_model[k] = (k < NUM_WIN) ? wins[k] : '0;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_window(input int centre, input int spread);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = 16'(centre - $urandom_range(spread));
        hi = 16'(centre + $urandom_range(spread));
        return {hi, lo};
    endfunction

    // plausible remote timings, jittered around the usual values
    function automatic win_array_t sane_windows();
        win_array_t wins;
        wins[WIN_LEADER_LOW]  = rand_window(9000, 1500);
        wins[WIN_LEADER_HIGH] = rand_window(4500, 600);
        wins[WIN_REPEAT_HIGH] = rand_window(2250, 300);
        wins[WIN_BIT_LOW]     = rand_window(560, 200);
        wins[WIN_ZERO_HIGH]   = rand_window(560, 200);
        wins[WIN_ONE_HIGH]    = rand_window(1690, 300);
        return wins;
    endfunction

    // any ordered pair of limits, so windows overlap freely
    function automatic win_array_t wild_windows();
        win_array_t wins;
        int k;
        logic [15:0] p;
        logic [15:0] q;
        for (k = 0; k < NUM_WIN; k++)
        begin
            p = 16'($urandom);
            q = 16'($urandom);
            wins[k] = (p <= q) ? {q, p} : {p, q};
        end
        return wins;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, what, want, got);
        end
    endtask

    // output side: random back-pressure, steady for a stretch
    always @(posedge clk)
        m_axis_tready <= (checked >= CALM_LO && checked < CALM_HI) ||
                         ($urandom_range(99) >= 30);

    // compare each report item with the oldest prediction
    always @(posedge clk)
    begin : watch_results
        ir_report_t want;
        ir_report_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            checked++;
            if (report_q.size() == 0)
            begin
                errors++;
                $display("%0t: report item with nothing outstanding, expected none, actual %h",
                         $time, got);
            end
            else
            begin
                want = report_q.pop_front();
                check_field("ready_res", 32'(want.ready), 32'(got.ready));
                check_field("repeat_flag", 32'(want.rep), 32'(got.rep));
                check_field("raw_frame", want.frame, got.frame);
                check_field("address_byte", 32'(want.addr), 32'(got.addr));
                check_field("command_byte", 32'(want.cmd), 32'(got.cmd));
                check_field("address_check_ok", 32'(want.addr_ok), 32'(got.addr_ok));
                check_field("command_check_ok", 32'(want.cmd_ok), 32'(got.cmd_ok));
                check_field("held_command", 32'(want.held), 32'(got.held));
                check_field("decoder_phase", 32'(want.phase), 32'(got.phase));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("nec_ir_edge_decoder_unit verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        win_array_t wins;
        int i;
        win_model = default_windows();

        // directed table, default windows; reports typed where they are obvious
        add_probe(ACT_CLEAR, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // rising edge in idle is ignored
        add_probe(ACT_EDGE, 16'h1234, 1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // leader starts just below the timer wrap
        add_probe(ACT_EDGE, 16'hEDBC, 1'b0, 1'b1, 1'b0, 1'b0, PH_LEAD_LOW);
        // leader low at its minimum, across the wrap
        add_probe(ACT_EDGE, 16'd8500, 1'b1, 1'b1, 1'b0, 1'b0, PH_LEAD_HIGH);
        // repeat gap at its minimum
        add_probe(ACT_EDGE, 16'd2000, 1'b0, 1'b1, 1'b1, 1'b1, PH_IDLE);
        // a new leader keeps ready and the repeat flag
        add_probe(ACT_EDGE, 16'd777, 1'b0, 1'b1, 1'b1, 1'b1, PH_LEAD_LOW);
        add_probe(ACT_CLEAR, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // leader low one over its maximum
        add_probe(ACT_EDGE, 16'd100, 1'b0, 1'b1, 1'b0, 1'b0, PH_LEAD_LOW);
        add_probe(ACT_EDGE, 16'd9501, 1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // leader low at its maximum, then an edge of the wrong direction
        add_probe(ACT_EDGE, 16'd50, 1'b0, 1'b1, 1'b0, 1'b0, PH_LEAD_LOW);
        add_probe(ACT_EDGE, 16'd9500, 1'b1, 1'b1, 1'b0, 1'b0, PH_LEAD_HIGH);
        add_probe(ACT_EDGE, 16'd100, 1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // leader low one under its minimum
        add_probe(ACT_EDGE, 16'd40, 1'b0, 1'b1, 1'b0, 1'b0, PH_LEAD_LOW);
        add_probe(ACT_EDGE, 16'd8499, 1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // leader gap between the repeat and normal windows
        add_probe(ACT_EDGE, 16'd60, 1'b0, 1'b1, 1'b0, 1'b0, PH_LEAD_LOW);
        add_probe(ACT_EDGE, 16'd9000, 1'b1, 1'b1, 1'b0, 1'b0, PH_LEAD_HIGH);
        add_probe(ACT_EDGE, 16'd3000, 1'b0, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // leader gap at its minimum, then bits at window edges
        add_probe(ACT_EDGE, 16'd10, 1'b0, 1'b1, 1'b0, 1'b0, PH_LEAD_LOW);
        add_probe(ACT_EDGE, 16'd8500, 1'b1, 1'b1, 1'b0, 1'b0, PH_LEAD_HIGH);
        add_probe(ACT_EDGE, 16'd4000, 1'b0, 1'b1, 1'b0, 1'b0, PH_DATA);
        add_probe(ACT_EDGE, 16'd400, 1'b1, 1'b1, 1'b0, 1'b0, PH_DATA);
        add_probe(ACT_EDGE, 16'd1900, 1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE);
        add_probe(ACT_EDGE, 16'd700, 1'b1, 1'b0, 1'b0, 1'b0, PH_IDLE);
        add_probe(ACT_EDGE, 16'd400, 1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE);
        // bit low pulse one under its minimum drops the frame
        add_probe(ACT_EDGE, 16'd399, 1'b1, 1'b1, 1'b0, 1'b0, PH_IDLE);
        // repeat gap at its maximum
        add_probe(ACT_EDGE, 16'd20, 1'b0, 1'b1, 1'b0, 1'b0, PH_LEAD_LOW);
        add_probe(ACT_EDGE, 16'd9000, 1'b1, 1'b1, 1'b0, 1'b0, PH_LEAD_HIGH);
        add_probe(ACT_EDGE, 16'd2500, 1'b0, 1'b1, 1'b1, 1'b1, PH_IDLE);

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < probes.size(); i++)
            send_item(probes[i].kind, probes[i].ts, probes[i].lvl, probes[i].typed,
                      idle_report(probes[i].ready, probes[i].rep, probes[i].ph));

        // default windows, with one full drain part way through
        run_traffic(250);
        drain();
        run_traffic(450);

        // jittered realistic windows
        wins = sane_windows();
        apply_windows(wins, 1'b0);
        run_traffic(850);

        // extremes: open, single-value, zero-only and inverted windows
        wins[WIN_LEADER_LOW]  = 32'hFFFF_0000;
        wins[WIN_LEADER_HIGH] = 32'hFFFF_FFFF;
        wins[WIN_REPEAT_HIGH] = 32'h0000_0000;
        wins[WIN_BIT_LOW]     = 32'hFFFF_0000;
        wins[WIN_ZERO_HIGH]   = 32'h0000_FFFF;
        wins[WIN_ONE_HIGH]    = 32'hFFFF_0000;
        apply_windows(wins, 1'b0);
        run_traffic(1150);

        // arbitrary overlapping windows
        wins = wild_windows();
        apply_windows(wins, 1'b0);
        run_traffic(1550);

        // back to the defaults, also poking the unused indexes
        apply_windows(default_windows(), 1'b1);
        run_traffic(1930);

        drain();
        repeat (4)
            @(posedge clk);

        $display("covered %0d items (%0d clears) under five window settings,", sent, clears);
        $display("with %0d frames and %0d repeat codes decoded, %0d reports compared",
                 frames_done, repeats_done, checked);
        if (errors == 0)
            $display("nec_ir_edge_decoder_unit verification clean");
        else
            $display("nec_ir_edge_decoder_unit verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/necir_pkg.sv
rtl/necir_step.sv
rtl/nec_ir_edge_decoder_unit.sv
verif/tb_nec_ir_edge_decoder_unit.sv
